// ===== src/ncr_pkg.sv =====
`default_nettype none

package ncr_pkg;

  localparam int CP_W = 21;

  localparam logic [CP_W-1:0] CP_MAX         = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [CP_W-1:0] SURR_LO        = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI        = 21'h00DFFF;
  localparam logic [CP_W-1:0] C1_LO          = 21'h000080;
  localparam logic [CP_W-1:0] C1_HI          = 21'h00009F;

  // One finished reference: gathered code point plus overflow flag.
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            too_large;
  } char_t;

  // UTF-8 encoding of one character; byte 0 goes out first.
  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      n;
  } enc_t;

  // Windows-1252 replacements for 0x80..0x9F; zero marks an unlisted code.
  function automatic logic [15:0] c1_map(input logic [4:0] idx);
    logic [15:0] v;
    case (idx)
      5'd0:    v = 16'h20AC;
      5'd2:    v = 16'h201A;
      5'd3:    v = 16'h0192;
      5'd4:    v = 16'h201E;
      5'd5:    v = 16'h2026;
      5'd6:    v = 16'h2020;
      5'd7:    v = 16'h2021;
      5'd8:    v = 16'h02C6;
      5'd9:    v = 16'h2030;
      5'd10:   v = 16'h0160;
      5'd11:   v = 16'h2039;
      5'd12:   v = 16'h0152;
      5'd14:   v = 16'h017D;
      5'd17:   v = 16'h2018;
      5'd18:   v = 16'h2019;
      5'd19:   v = 16'h201C;
      5'd20:   v = 16'h201D;
      5'd21:   v = 16'h2022;
      5'd22:   v = 16'h2013;
      5'd23:   v = 16'h2014;
      5'd24:   v = 16'h02DC;
      5'd25:   v = 16'h2122;
      5'd26:   v = 16'h0161;
      5'd27:   v = 16'h203A;
      5'd28:   v = 16'h0153;
      5'd30:   v = 16'h017E;
      5'd31:   v = 16'h0178;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== src/ncr_in_if.sv =====
`default_nettype none

interface ncr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] digit_char;
  logic       hex_mode;
  logic       last_digit;

  modport source(output valid, output digit_char, output hex_mode, output last_digit,
                 input ready);
  modport sink(input valid, input digit_char, input hex_mode, input last_digit,
               output ready);
endinterface

`default_nettype wire

// ===== src/ncr_out_if.sv =====
`default_nettype none

interface ncr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] utf8_byte;
  logic       byte_last;

  modport source(output valid, output utf8_byte, output byte_last, input ready);
  modport sink(input valid, input utf8_byte, input byte_last, output ready);
endinterface

`default_nettype wire

// ===== src/numeric_char_ref_to_utf8_core.sv =====
`default_nettype none

// Numeric character reference decoder with UTF-8 output. Feed the digit
// text of one reference (the part after "&#" or "&#x"), one character per
// transfer on chars, with hex_mode set for base sixteen and last_digit on
// the final character. The first character that is not a digit of the
// base freezes the value for the rest of the reference; a value above
// 0x10FFFF is flagged and, like zero and surrogates, decodes as U+FFFD,
// while the listed C1 codes 0x80..0x9F map to their Windows-1252
// characters. After the last character the block sends the UTF-8 bytes
// of the result on bytes, one byte per transfer, byte_last on the final
// one, and starts the next reference from zero. The accumulator folds in
// each character as it is accepted; a finished reference is encoded
// between a character register and a byte shift register and leaves at
// one byte per cycle while bytes is ready. The only input stall comes
// from the byte shift register: any character waits while a finished
// character is held in the character register and the result before it
// still has more than one byte queued, or its last byte is not taken.
// After the last character, the result passes the character register
// and then the byte shift register before its first byte leaves.
module numeric_char_ref_to_utf8_core (
  input  wire logic clk,
  input  wire logic rst,
  ncr_in_if.sink    chars,
  ncr_out_if.source bytes
);

  ncr_pkg::char_t chr;
  logic           chr_valid;
  logic           chr_take;
  ncr_pkg::enc_t  enc;

  // Accumulate digits; hold the finished code point for the encoder.
  ncr_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars),
    .chr       (chr),
    .chr_valid (chr_valid),
    .chr_take  (chr_take)
  );

  // Apply replacements and build up to four UTF-8 bytes.
  ncr_encode u_encode (
    .chr (chr),
    .enc (enc)
  );

  // Drain the bytes one transfer at a time.
  ncr_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .enc       (enc),
    .enc_valid (chr_valid),
    .enc_take  (chr_take),
    .bytes     (bytes)
  );

endmodule

`default_nettype wire

// ===== src/ncr_accum.sv =====
`default_nettype none

module ncr_accum (
  input  wire logic          clk,
  input  wire logic          rst,
  ncr_in_if.sink             chars,
  output ncr_pkg::char_t     chr,
  output logic               chr_valid,
  input  wire logic          chr_take
);

  logic [ncr_pkg::CP_W-1:0] acc;
  logic                     too_large;
  logic                     stopped;

  logic                     accept;
  logic                     dv;
  logic [3:0]               dval;
  logic [24:0]              prod;
  logic [24:0]              sum;
  logic [ncr_pkg::CP_W-1:0] acc_next;
  logic                     too_large_next;
  logic                     stopped_next;

  assign chars.ready = !chr_valid || chr_take;
  assign accept      = chars.valid && chars.ready;

  // Digit decode for the item's own base.
  always_comb begin
    dv   = 1'b0;
    dval = 4'd0;
    if (chars.digit_char >= 8'h30 && chars.digit_char <= 8'h39) begin
      dv   = 1'b1;
      dval = chars.digit_char[3:0];
    end else if (chars.hex_mode && chars.digit_char >= 8'h61 && chars.digit_char <= 8'h66) begin
      dv   = 1'b1;
      dval = 4'(chars.digit_char - 8'h57);
    end else if (chars.hex_mode && chars.digit_char >= 8'h41 && chars.digit_char <= 8'h46) begin
      dv   = 1'b1;
      dval = 4'(chars.digit_char - 8'h37);
    end
  end

  // Times sixteen is a shift, times ten is the sum of two shifted copies.
  always_comb begin
    if (chars.hex_mode) begin
      prod = {acc, 4'b0000};
    end else begin
      prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
    end
    sum = prod + {21'd0, dval};
  end

  always_comb begin
    acc_next       = acc;
    too_large_next = too_large;
    stopped_next   = stopped;
    if (!too_large && !stopped) begin
      if (!dv) begin
        stopped_next = 1'b1;
      end else if (sum > {4'd0, ncr_pkg::CP_MAX}) begin
        too_large_next = 1'b1;
      end else begin
        acc_next = sum[ncr_pkg::CP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      too_large <= 1'b0;
      stopped   <= 1'b0;
      chr_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (chars.last_digit) begin
          acc       <= '0;
          too_large <= 1'b0;
          stopped   <= 1'b0;
        end else begin
          acc       <= acc_next;
          too_large <= too_large_next;
          stopped   <= stopped_next;
        end
      end
      if (accept && chars.last_digit) begin
        chr_valid <= 1'b1;
      end else if (chr_take) begin
        chr_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && chars.last_digit) begin
      chr.cp        <= acc_next;
      chr.too_large <= too_large_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/ncr_encode.sv =====
`default_nettype none

module ncr_encode (
  input  wire ncr_pkg::char_t chr,
  output ncr_pkg::enc_t       enc
);

  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD4 = 8'hF0;
  localparam logic [7:0] CONT  = 8'h80;

  logic [ncr_pkg::CP_W-1:0] fc;
  logic [15:0]              c1;

  assign c1 = ncr_pkg::c1_map(chr.cp[4:0]);

  // Replace zero, overflow and surrogates; remap listed C1 codes.
  always_comb begin
    fc = chr.cp;
    if (chr.too_large || chr.cp == '0) begin
      fc = ncr_pkg::CP_REPLACEMENT;
    end else if (chr.cp >= ncr_pkg::C1_LO && chr.cp <= ncr_pkg::C1_HI && c1 != 16'h0000) begin
      fc = {5'd0, c1};
    end else if (chr.cp >= ncr_pkg::SURR_LO && chr.cp <= ncr_pkg::SURR_HI) begin
      fc = ncr_pkg::CP_REPLACEMENT;
    end else if (chr.cp > ncr_pkg::CP_MAX) begin
      fc = ncr_pkg::CP_REPLACEMENT;
    end
  end

  always_comb begin
    enc.b = '0;
    if (fc <= 21'h00007F) begin
      enc.b[0] = fc[7:0];
      enc.n    = 3'd1;
    end else if (fc <= 21'h0007FF) begin
      enc.b[0] = LEAD2 | {3'b000, fc[10:6]};
      enc.b[1] = CONT | {2'b00, fc[5:0]};
      enc.n    = 3'd2;
    end else if (fc <= 21'h00FFFF) begin
      enc.b[0] = LEAD3 | {4'b0000, fc[15:12]};
      enc.b[1] = CONT | {2'b00, fc[11:6]};
      enc.b[2] = CONT | {2'b00, fc[5:0]};
      enc.n    = 3'd3;
    end else begin
      enc.b[0] = LEAD4 | {5'b00000, fc[20:18]};
      enc.b[1] = CONT | {2'b00, fc[17:12]};
      enc.b[2] = CONT | {2'b00, fc[11:6]};
      enc.b[3] = CONT | {2'b00, fc[5:0]};
      enc.n    = 3'd4;
    end
  end

endmodule

`default_nettype wire

// ===== src/ncr_outbuf.sv =====
`default_nettype none

module ncr_outbuf (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ncr_pkg::enc_t enc,
  input  wire logic          enc_valid,
  output logic               enc_take,
  ncr_out_if.source          bytes
);

  logic [3:0][7:0] sh;
  logic [2:0]      rem;
  logic            xfer;

  assign bytes.valid     = (rem != 3'd0);
  assign bytes.utf8_byte = sh[0];
  assign bytes.byte_last = (rem == 3'd1);

  assign xfer     = bytes.valid && bytes.ready;
  // Load the next character when empty or as the last byte of this one leaves.
  assign enc_take = enc_valid && ((rem == 3'd0) || (rem == 3'd1 && bytes.ready));

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 3'd0;
    end else if (enc_take) begin
      rem <= enc.n;
    end else if (xfer) begin
      rem <= rem - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (enc_take) begin
      sh <= enc.b;
    end else if (xfer) begin
      sh <= {8'h00, sh[3:1]};
    end
  end

endmodule

`default_nettype wire
